@@ src/assert_macros.svh @@
// Assertion macros for the framer RTL, used by the frame emitter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge outside reset.
`define ASSERT_AT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition never holds on a rising clk edge outside reset.
`define ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

@@ src/nqsf_pkg.sv @@
// Types, constants and character helpers for the QZQSM sentence framer.
`default_nettype none

package nqsf_pkg;

	localparam int SENTENCE_CAPACITY = 128;
	localparam int ADDR_W = $clog2(SENTENCE_CAPACITY);
	localparam int TAG_LEN = 6;
	localparam int PAYLOAD_DIGITS = 63;
	localparam int RUN_W = 6;
	localparam int ID_MAX = 255;
	localparam logic [2:0] LAST_WORD_IDX = 3'd7;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR = 8'h2A;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CK_INVALID = 8'hFF;

	typedef enum logic [1:0] {
		MODE_WAIT,
		MODE_COLLECT,
		MODE_CK_HI,
		MODE_CK_LO
	} mode_t;

	typedef enum logic [2:0] {
		PH_TAG,
		PH_ID,
		PH_RUN,
		PH_DONE,
		PH_BAD
	} phase_t;

	typedef enum logic [1:0] {
		EM_IDLE,
		EM_READ,
		EM_CAPTURE,
		EM_OUT
	} emit_state_t;

	typedef struct packed {
		logic              start;
		logic [7:0]        sat_id;
		logic [ADDR_W-1:0] run_start;
	} frame_t;

	function automatic logic is_dec(input logic [7:0] ch);
		return (ch >= 8'h30) && (ch <= 8'h39);
	endfunction

	function automatic logic is_hex(input logic [7:0] ch);
		return is_dec(ch) || ((ch >= 8'h41) && (ch <= 8'h46)) ||
			((ch >= 8'h61) && (ch <= 8'h66));
	endfunction

	// Nibble value of a hex character; anything else reads as F.
	function automatic logic [3:0] hex_val(input logic [7:0] ch);
		logic [3:0] v;
		if (is_dec(ch)) begin
			v = ch[3:0];
		end else if (is_hex(ch)) begin
			v = ch[3:0] + 4'd9;
		end else begin
			v = 4'hF;
		end
		return v;
	endfunction

	function automatic logic [7:0] tag_char(input logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0: c = 8'h51;
			3'd1: c = 8'h5A;
			3'd2: c = 8'h51;
			3'd3: c = 8'h53;
			3'd4: c = 8'h4D;
			3'd5: c = CH_COMMA;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

@@ src/nmea_qzqsm_sentence_framer_unit.sv @@
// Top level of the NMEA QZQSM sentence framer.
// Takes one NMEA character per cycle while collecting a sentence; the body is written
// into a 128-entry sentence RAM and parsed as it arrives, with no clearing pass after
// reset. When the checksum matches and the body is a valid QZQSM sentence, in_ready
// drops while the 63 payload digits are read back through the single RAM read port,
// one digit at a time (read, then capture), and eight 32-bit words leave on the
// output channel, each held until out_ready takes it.
`default_nettype none

module nmea_qzqsm_sentence_framer_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  rx_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       sat_id,
	output logic [2:0]       word_index,
	output logic [31:0]      payload_word,
	output logic             last_word
);

	nqsf_pkg::frame_t frame;
	logic emit_busy;
	logic wr_en;
	logic [nqsf_pkg::ADDR_W-1:0] wr_addr;
	logic [7:0] wr_data;
	logic rd_en;
	logic [nqsf_pkg::ADDR_W-1:0] rd_addr;
	logic [7:0] rd_data;

	nqsf_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.rx_byte   (rx_byte),
		.emit_busy (emit_busy),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.frame     (frame)
	);

	nqsf_ram #(
		.WIDTH (8),
		.DEPTH (nqsf_pkg::SENTENCE_CAPACITY)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	nqsf_emit u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.frame        (frame),
		.busy         (emit_busy),
		.rd_en        (rd_en),
		.rd_addr      (rd_addr),
		.rd_data      (rd_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.sat_id       (sat_id),
		.word_index   (word_index),
		.payload_word (payload_word),
		.last_word    (last_word)
	);

endmodule

`default_nettype wire

@@ src/nqsf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module nqsf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

@@ src/nqsf_parse.sv @@
// Sentence collector: body storage, running XOR, checksum and on-the-fly body parse.
`default_nettype none

module nqsf_parse (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic [7:0]                 rx_byte,
	input  wire logic                       emit_busy,
	output logic                            wr_en,
	output logic [nqsf_pkg::ADDR_W-1:0]     wr_addr,
	output logic [7:0]                      wr_data,
	output nqsf_pkg::frame_t                frame
);

	localparam int CW = nqsf_pkg::ADDR_W;

	nqsf_pkg::mode_t mode_q, mode_d;
	logic [CW-1:0] count_q;
	logic [7:0] xor_q;
	logic [3:0] ckh_q;

	nqsf_pkg::phase_t ph_q, ph_d;
	logic [7:0] id_q, id_d;
	logic anyd_q, anyd_d;
	logic [nqsf_pkg::RUN_W-1:0] run_q, run_d;
	logic [CW-1:0] start_q, start_d;

	logic accept;
	logic is_dollar;
	logic is_end;
	logic store;
	logic [11:0] nid;
	logic [7:0] got;
	logic parse_ok;

	assign in_ready = !emit_busy;
	assign accept = in_valid && in_ready;
	assign is_dollar = (rx_byte == nqsf_pkg::CH_DOLLAR);
	assign is_end = (rx_byte == nqsf_pkg::CH_CR) || (rx_byte == nqsf_pkg::CH_LF);
	assign store = (mode_q == nqsf_pkg::MODE_COLLECT) && !is_dollar &&
		(rx_byte != nqsf_pkg::CH_STAR) && !is_end &&
		(count_q < CW'(nqsf_pkg::SENTENCE_CAPACITY - 1));

	// id * 10 + digit
	assign nid = ({4'b0, id_q} << 3) + ({4'b0, id_q} << 1) + {8'b0, rx_byte[3:0]};

	assign got = nqsf_pkg::is_hex(rx_byte) ? {ckh_q, nqsf_pkg::hex_val(rx_byte)}
		: nqsf_pkg::CK_INVALID;
	assign parse_ok = (ph_q == nqsf_pkg::PH_DONE) ||
		((ph_q == nqsf_pkg::PH_RUN) &&
		(run_q == nqsf_pkg::RUN_W'(nqsf_pkg::PAYLOAD_DIGITS)));

	// Parse step for the character being stored at position count_q.
	always_comb begin
		ph_d = ph_q;
		id_d = id_q;
		anyd_d = anyd_q;
		run_d = run_q;
		start_d = start_q;
		case (ph_q)
			nqsf_pkg::PH_TAG: begin
				if (rx_byte != nqsf_pkg::tag_char(count_q[2:0])) begin
					ph_d = nqsf_pkg::PH_BAD;
				end else if (count_q == CW'(nqsf_pkg::TAG_LEN - 1)) begin
					ph_d = nqsf_pkg::PH_ID;
				end
			end
			nqsf_pkg::PH_ID: begin
				if (rx_byte == nqsf_pkg::CH_COMMA) begin
					ph_d = anyd_q ? nqsf_pkg::PH_RUN : nqsf_pkg::PH_BAD;
					start_d = count_q + CW'(1);
				end else if (nqsf_pkg::is_dec(rx_byte)) begin
					if (nid > 12'(nqsf_pkg::ID_MAX)) begin
						ph_d = nqsf_pkg::PH_BAD;
					end else begin
						id_d = nid[7:0];
						anyd_d = 1'b1;
					end
				end else begin
					ph_d = nqsf_pkg::PH_BAD;
				end
			end
			nqsf_pkg::PH_RUN: begin
				if (nqsf_pkg::is_hex(rx_byte)) begin
					// a 64th hex digit makes the run too long
					if (run_q == nqsf_pkg::RUN_W'(nqsf_pkg::PAYLOAD_DIGITS)) begin
						ph_d = nqsf_pkg::PH_BAD;
					end else begin
						run_d = run_q + nqsf_pkg::RUN_W'(1);
					end
				end else begin
					ph_d = (run_q == nqsf_pkg::RUN_W'(nqsf_pkg::PAYLOAD_DIGITS)) ?
						nqsf_pkg::PH_DONE : nqsf_pkg::PH_BAD;
				end
			end
			default: begin
				ph_d = ph_q;
			end
		endcase
	end

	// Next mode
	always_comb begin
		mode_d = mode_q;
		if (accept) begin
			if (is_dollar) begin
				mode_d = nqsf_pkg::MODE_COLLECT;
			end else begin
				case (mode_q)
					nqsf_pkg::MODE_COLLECT: begin
						if (rx_byte == nqsf_pkg::CH_STAR) begin
							mode_d = nqsf_pkg::MODE_CK_HI;
						end else if (!store) begin
							mode_d = nqsf_pkg::MODE_WAIT;
						end
					end
					nqsf_pkg::MODE_CK_HI: mode_d = nqsf_pkg::MODE_CK_LO;
					nqsf_pkg::MODE_CK_LO: mode_d = nqsf_pkg::MODE_WAIT;
					default: mode_d = mode_q;
				endcase
			end
		end
	end

	// Outputs
	always_comb begin
		wr_en = accept && store;
		wr_addr = count_q;
		wr_data = rx_byte;
		frame.start = accept && !is_dollar && (mode_q == nqsf_pkg::MODE_CK_LO) &&
			(got == xor_q) && parse_ok;
		frame.sat_id = id_q;
		frame.run_start = start_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= nqsf_pkg::MODE_WAIT;
			count_q <= '0;
			xor_q <= '0;
			ckh_q <= '0;
			ph_q <= nqsf_pkg::PH_TAG;
			id_q <= '0;
			anyd_q <= 1'b0;
			run_q <= '0;
			start_q <= '0;
		end else begin
			mode_q <= mode_d;
			if (accept) begin
				if (is_dollar) begin
					count_q <= '0;
					xor_q <= '0;
					ph_q <= nqsf_pkg::PH_TAG;
					id_q <= '0;
					anyd_q <= 1'b0;
					run_q <= '0;
				end else begin
					case (mode_q)
						nqsf_pkg::MODE_COLLECT: begin
							if (store) begin
								count_q <= count_q + CW'(1);
								xor_q <= xor_q ^ rx_byte;
								ph_q <= ph_d;
								id_q <= id_d;
								anyd_q <= anyd_d;
								run_q <= run_d;
								start_q <= start_d;
							end else if (rx_byte != nqsf_pkg::CH_STAR) begin
								// drop the sentence
								count_q <= '0;
								xor_q <= '0;
							end
						end
						nqsf_pkg::MODE_CK_HI: ckh_q <= nqsf_pkg::hex_val(rx_byte);
						default: ckh_q <= ckh_q;
					endcase
				end
			end
		end
	end

endmodule

`default_nettype wire

@@ src/nqsf_emit.sv @@
// Frame emitter: reads the hex run back from the sentence RAM and packs 32-bit words.
`default_nettype none

`include "assert_macros.svh"

module nqsf_emit (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire nqsf_pkg::frame_t           frame,
	output logic                            busy,
	output logic                            rd_en,
	output logic [nqsf_pkg::ADDR_W-1:0]     rd_addr,
	input  wire logic [7:0]                 rd_data,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic [7:0]                      sat_id,
	output logic [2:0]                      word_index,
	output logic [31:0]                     payload_word,
	output logic                            last_word
);

	nqsf_pkg::emit_state_t state_q, state_d;
	logic [nqsf_pkg::ADDR_W-1:0] base_q;
	logic [nqsf_pkg::RUN_W-1:0] dig_q;
	logic [7:0] sat_q;
	logic [2:0] widx_q;
	logic [31:0] word_q;
	logic last_dig;
	logic word_full;
	logic [3:0] nib;

	assign last_dig = (dig_q == nqsf_pkg::RUN_W'(nqsf_pkg::PAYLOAD_DIGITS - 1));
	assign word_full = (dig_q[2:0] == 3'd7) || last_dig;
	assign nib = nqsf_pkg::hex_val(rd_data);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			nqsf_pkg::EM_IDLE: begin
				if (frame.start) begin
					state_d = nqsf_pkg::EM_READ;
				end
			end
			nqsf_pkg::EM_READ: state_d = nqsf_pkg::EM_CAPTURE;
			nqsf_pkg::EM_CAPTURE: begin
				state_d = word_full ? nqsf_pkg::EM_OUT : nqsf_pkg::EM_READ;
			end
			nqsf_pkg::EM_OUT: begin
				if (out_ready) begin
					state_d = (widx_q == nqsf_pkg::LAST_WORD_IDX) ?
						nqsf_pkg::EM_IDLE : nqsf_pkg::EM_READ;
				end
			end
			default: state_d = nqsf_pkg::EM_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		busy = (state_q != nqsf_pkg::EM_IDLE);
		rd_en = (state_q == nqsf_pkg::EM_READ);
		rd_addr = base_q + nqsf_pkg::ADDR_W'(dig_q);
		out_valid = (state_q == nqsf_pkg::EM_OUT);
		sat_id = sat_q;
		word_index = widx_q;
		payload_word = word_q;
		last_word = (widx_q == nqsf_pkg::LAST_WORD_IDX);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nqsf_pkg::EM_IDLE;
			dig_q <= '0;
			widx_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == nqsf_pkg::EM_IDLE && frame.start) begin
				dig_q <= '0;
			end else if (state_q == nqsf_pkg::EM_CAPTURE) begin
				dig_q <= dig_q + nqsf_pkg::RUN_W'(1);
				widx_q <= dig_q[5:3];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == nqsf_pkg::EM_IDLE && frame.start) begin
			base_q <= frame.run_start;
			sat_q <= frame.sat_id;
		end
		if (state_q == nqsf_pkg::EM_CAPTURE) begin
			// the final digit fills the high half of byte 31; pad the low half
			if (last_dig) begin
				word_q <= {word_q[23:0], nib, 4'h0};
			end else begin
				word_q <= {word_q[27:0], nib};
			end
		end
	end

	`ASSERT_AT(a_start_idle, frame.start |-> state_q == nqsf_pkg::EM_IDLE, "frame start while emitting")
	`ASSERT_AT(a_last_done, (state_q == nqsf_pkg::EM_OUT && out_ready && widx_q == nqsf_pkg::LAST_WORD_IDX) |=> state_q == nqsf_pkg::EM_IDLE, "emitter did not finish after last word")
	`ASSERT_AT(a_last_digits, (state_q == nqsf_pkg::EM_OUT && widx_q == nqsf_pkg::LAST_WORD_IDX) |-> dig_q == nqsf_pkg::RUN_W'(nqsf_pkg::PAYLOAD_DIGITS), "last word before all digits read")
	`ASSERT_NEVER(a_digit_overrun, state_q == nqsf_pkg::EM_CAPTURE && dig_q > nqsf_pkg::RUN_W'(nqsf_pkg::PAYLOAD_DIGITS - 1), "read past the hex run")

endmodule

`default_nettype wire

@@ sim/nmea_qzqsm_sentence_framer_unit_test.sv @@
// Self-checking testbench for the NMEA QZQSM sentence framer: directed sentences, then random traffic.
`timescale 1ns / 1ps

module nmea_qzqsm_sentence_framer_unit_test;

	localparam int IDLE_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 300;
	localparam int MAX_REPORTS = 10;
	localparam int RANDOM_BYTES = 250;
	localparam int PLAN_ROWS = 22;

	typedef logic [7:0] octet_t;

	typedef enum {
		S_GOOD, S_TAIL, S_ZERO_TAIL, S_FULL, S_OVERFLOW, S_ID_BIG, S_ID_EMPTY, S_ID_ALPHA,
		S_ID_ZERO_BYTE, S_RUN_SHORT, S_RUN_LONG, S_BAD_TAG, S_BAD_SUM, S_CR, S_LF,
		S_RESTART_BODY, S_RESTART_SUM, S_HI_BAD, S_LO_BAD, S_NOISE
	} shape_t;

	typedef enum {FILL_ZERO, FILL_ONES, FILL_RANDOM} fill_t;

	typedef struct {
		shape_t shape;
		int     id;
		fill_t  fill;
		int     want;	// frames the sentence must yield, -1 when left to the predictor
	} row_t;

	typedef struct packed {
		logic [7:0]  sat_id;
		logic [2:0]  word_index;
		logic [31:0] payload_word;
		logic        last_word;
	} frame_word_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  rx_byte;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  sat_id;
	logic [2:0]  word_index;
	logic [31:0] payload_word;
	logic        last_word;

	nmea_qzqsm_sentence_framer_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.sat_id       (sat_id),
		.word_index   (word_index),
		.payload_word (payload_word),
		.last_word    (last_word)
	);

	// Sentence tracker state
	nqsf_pkg::mode_t rx_mode;
	int          body_len;
	octet_t      body_xor;
	logic [3:0]  sum_hi;
	octet_t      body_mem [nqsf_pkg::SENTENCE_CAPACITY];
	frame_word_t pending_words[$];
	string       tag_text = "QZQSM,";

	octet_t      line_q[$];
	int          frames_made = 0;
	int          words_seen = 0;
	int          bytes_sent = 0;
	int          sentences_sent = 0;
	int          faults = 0;
	int          burst_left = 0;
	int          idle_cycles = 0;
	int          ready_hold = 0;
	logic [2:0]  ready_phase = '0;
	logic [7:0]  ready_mask = 8'hFF;

	row_t plan [PLAN_ROWS] = '{
		'{S_GOOD, 0, FILL_ZERO, 1},
		'{S_GOOD, 255, FILL_ONES, 1},
		'{S_GOOD, 7, FILL_RANDOM, 1},
		'{S_TAIL, 123, FILL_RANDOM, 1},
		'{S_ZERO_TAIL, 42, FILL_RANDOM, 1},
		'{S_FULL, 200, FILL_RANDOM, 1},
		'{S_OVERFLOW, 200, FILL_RANDOM, 0},
		'{S_ID_BIG, 256, FILL_RANDOM, 0},
		'{S_ID_EMPTY, 0, FILL_RANDOM, 0},
		'{S_ID_ALPHA, 12, FILL_RANDOM, 0},
		'{S_ID_ZERO_BYTE, 5, FILL_RANDOM, 0},
		'{S_RUN_SHORT, 9, FILL_RANDOM, 0},
		'{S_RUN_LONG, 9, FILL_RANDOM, 0},
		'{S_BAD_TAG, 1, FILL_RANDOM, 0},
		'{S_BAD_SUM, 1, FILL_RANDOM, 0},
		'{S_CR, 3, FILL_RANDOM, 0},
		'{S_LF, 3, FILL_RANDOM, 0},
		'{S_RESTART_BODY, 77, FILL_RANDOM, 1},
		'{S_RESTART_SUM, 78, FILL_RANDOM, 1},
		'{S_HI_BAD, 99, FILL_RANDOM, 1},
		'{S_LO_BAD, 100, FILL_RANDOM, 1},
		'{S_NOISE, 0, FILL_ZERO, 0}
	};

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic void note_fault(input string msg);
		faults++;
		if (faults <= MAX_REPORTS) begin
			$display("MISMATCH: %s", msg);
		end
	endfunction

	// Bit 4 set marks a character that is not a hex digit.
	function automatic logic [4:0] hex_code(input octet_t ch);
		if (ch >= "0" && ch <= "9") return {1'b0, ch[3:0]};
		if (ch >= "A" && ch <= "F") return {1'b0, 4'(ch - "A" + 8'd10)};
		if (ch >= "a" && ch <= "f") return {1'b0, 4'(ch - "a" + 8'd10)};
		return 5'h10;
	endfunction

	function automatic octet_t xor_of(input octet_t q[$]);
		octet_t x = '0;
		foreach (q[i]) x ^= q[i];
		return x;
	endfunction

	task automatic decode_frame();
		int          p;
		int          run;
		int          id;
		bit          got_digit;
		logic [4:0]  h;
		octet_t      pay [32];
		frame_word_t fw;
		id = 0;
		got_digit = 0;
		if (body_len < nqsf_pkg::TAG_LEN) return;
		for (int i = 0; i < nqsf_pkg::TAG_LEN; i++) begin
			if (body_mem[i] != tag_text[i]) return;
		end
		p = nqsf_pkg::TAG_LEN;
		while (p < body_len && body_mem[p] != nqsf_pkg::CH_COMMA) begin
			if (body_mem[p] < "0" || body_mem[p] > "9") return;
			id = id * 10 + int'(body_mem[p] - "0");
			got_digit = 1;
			if (id > nqsf_pkg::ID_MAX) return;
			p++;
		end
		if (!got_digit || p >= body_len) return;
		p++;
		run = 0;
		while (p + run < body_len) begin
			h = hex_code(body_mem[p + run]);
			if (h[4]) break;
			run++;
		end
		if (run != nqsf_pkg::PAYLOAD_DIGITS) return;
		foreach (pay[i]) pay[i] = '0;
		for (int i = 0; i < nqsf_pkg::PAYLOAD_DIGITS; i++) begin
			h = hex_code(body_mem[p + i]);
			if (i % 2 == 0) pay[i / 2][7:4] = h[3:0];
			else pay[i / 2][3:0] = h[3:0];
		end
		for (int k = 0; k < 8; k++) begin
			fw.sat_id = id[7:0];
			fw.word_index = 3'(k);
			fw.payload_word = {pay[4 * k], pay[4 * k + 1], pay[4 * k + 2],
				pay[4 * k + 3]};
			fw.last_word = (fw.word_index == nqsf_pkg::LAST_WORD_IDX);
			pending_words.push_back(fw);
		end
		frames_made++;
	endtask

	task automatic take_char(input octet_t ch);
		logic [4:0] h;
		octet_t     got;
		h = hex_code(ch);
		if (ch == nqsf_pkg::CH_DOLLAR) begin
			rx_mode = nqsf_pkg::MODE_COLLECT;
			body_len = 0;
			body_xor = '0;
		end else begin
			case (rx_mode)
				nqsf_pkg::MODE_COLLECT: begin
					if (ch == nqsf_pkg::CH_STAR) begin
						rx_mode = nqsf_pkg::MODE_CK_HI;
					end else if (ch == nqsf_pkg::CH_CR || ch == nqsf_pkg::CH_LF ||
							body_len >= nqsf_pkg::SENTENCE_CAPACITY - 1) begin
						rx_mode = nqsf_pkg::MODE_WAIT;
						body_len = 0;
						body_xor = '0;
					end else begin
						body_mem[body_len] = ch;
						body_xor ^= ch;
						body_len++;
					end
				end
				nqsf_pkg::MODE_CK_HI: begin
					sum_hi = h[4] ? 4'hF : h[3:0];
					rx_mode = nqsf_pkg::MODE_CK_LO;
				end
				nqsf_pkg::MODE_CK_LO: begin
					got = h[4] ? nqsf_pkg::CK_INVALID : {sum_hi, h[3:0]};
					rx_mode = nqsf_pkg::MODE_WAIT;
					if (got == body_xor) decode_frame();
				end
				default: ;
			endcase
		end
	endtask

	task automatic check_word();
		frame_word_t seen;
		frame_word_t want;
		seen = {sat_id, word_index, payload_word, last_word};
		words_seen++;
		if (pending_words.size() == 0) begin
			note_fault($sformatf("unexpected word: sat %0d idx %0d data %08h last %0b",
				seen.sat_id, seen.word_index, seen.payload_word, seen.last_word));
			return;
		end
		want = pending_words.pop_front();
		if (seen.sat_id !== want.sat_id || seen.word_index !== want.word_index ||
				seen.payload_word !== want.payload_word ||
				seen.last_word !== want.last_word) begin
			note_fault($sformatf({"expected sat %0d idx %0d data %08h last %0b, ",
				"got sat %0d idx %0d data %08h last %0b"},
				want.sat_id, want.word_index, want.payload_word, want.last_word,
				seen.sat_id, seen.word_index, seen.payload_word, seen.last_word));
		end
	endtask

	// Check outputs before predicting: a byte accepted now cannot cause a word on this edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) check_word();
			if (in_valid && in_ready) take_char(rx_byte);
			if ((out_valid && out_ready) || (in_valid && in_ready)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Watchdog: %0d cycles without a transaction", IDLE_LIMIT);
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// Receiver stalls follow a rotating 8-bit mask; bit 0 always set bounds each stall.
	always @(negedge clk) begin
		if (ready_hold == 0) begin
			ready_hold = $urandom_range(16, 128);
			case ($urandom_range(0, 3))
				0: ready_mask = 8'hFF;
				1: ready_mask = 8'($urandom_range(0, 255)) | 8'h01;
				2: ready_mask = 8'h01;
				default: ready_mask = 8'h0F;
			endcase
		end
		ready_hold--;
		ready_phase++;
		out_ready = ready_mask[ready_phase];
	end

	function automatic octet_t hex_char(input logic [3:0] n, input bit lower);
		octet_t c;
		c = (n < 4'd10) ? 8'(n + "0") : 8'(n - 10 + "A");
		if (lower && n >= 4'd10) c = c | 8'h20;
		return c;
	endfunction

	function automatic octet_t filler_char();
		octet_t c;
		do begin
			c = 8'($urandom_range(0, 255));
		end while (c == nqsf_pkg::CH_DOLLAR || c == nqsf_pkg::CH_STAR ||
			c == nqsf_pkg::CH_CR || c == nqsf_pkg::CH_LF);
		return c;
	endfunction

	// Neither a hex digit nor a comma, and harmless inside a body.
	function automatic octet_t odd_char();
		octet_t     c;
		logic [4:0] h;
		do begin
			c = filler_char();
			h = hex_code(c);
		end while (!h[4] || c == nqsf_pkg::CH_COMMA);
		return c;
	endfunction

	task automatic build_sentence(input shape_t shape, input int id, input fill_t fill);
		octet_t     body[$];
		octet_t     sum;
		octet_t     target;
		octet_t     sep;
		octet_t     pad;
		string      digits;
		int         ndig;
		int         cut;
		bit         lower;
		logic [3:0] nib;
		line_q.delete();
		lower = 1'($urandom_range(0, 1));
		if (shape == S_NOISE) begin
			line_q.push_back(8'hFF);
			line_q.push_back(8'h00);
			repeat ($urandom_range(1, 12)) line_q.push_back(8'($urandom_range(0, 255)));
			return;
		end
		foreach (tag_text[i]) body.push_back(tag_text[i]);
		if (shape == S_BAD_TAG) body[$urandom_range(0, nqsf_pkg::TAG_LEN - 1)] ^= 8'h20;
		if (shape != S_ID_EMPTY) begin
			if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) body.push_back("0");
			digits = $sformatf("%0d", id);
			foreach (digits[i]) body.push_back(digits[i]);
		end
		if (shape == S_ID_ALPHA)
			body.insert($urandom_range(nqsf_pkg::TAG_LEN, body.size()), odd_char());
		if (shape == S_ID_ZERO_BYTE)
			body.insert($urandom_range(nqsf_pkg::TAG_LEN, body.size()), 8'h00);
		body.push_back(nqsf_pkg::CH_COMMA);
		ndig = nqsf_pkg::PAYLOAD_DIGITS;
		if (shape == S_RUN_SHORT) ndig--;
		if (shape == S_RUN_LONG) ndig++;
		for (int i = 0; i < ndig; i++) begin
			case (fill)
				FILL_ZERO: nib = 4'h0;
				FILL_ONES: nib = 4'hF;
				default:   nib = 4'($urandom_range(0, 15));
			endcase
			body.push_back(hex_char(nib,
				(fill == FILL_RANDOM) ? 1'($urandom_range(0, 1)) : lower));
		end
		case (shape)
			S_TAIL: begin
				body.push_back(odd_char());
				repeat ($urandom_range(1, 20)) body.push_back(filler_char());
			end
			S_ZERO_TAIL: begin
				body.push_back(nqsf_pkg::CH_COMMA);
				body.push_back(8'h00);
				body.push_back("Z");
			end
			S_FULL, S_OVERFLOW: begin
				body.push_back(odd_char());
				while (body.size() < nqsf_pkg::SENTENCE_CAPACITY - ((shape == S_FULL) ? 1 : 0))
					body.push_back(filler_char());
			end
			S_CR: body.insert($urandom_range(0, body.size()), nqsf_pkg::CH_CR);
			S_LF: body.insert($urandom_range(0, body.size()), nqsf_pkg::CH_LF);
			S_HI_BAD, S_LO_BAD: begin
				// Append a separator and a pad byte that steer the body XOR to the target.
				target = (shape == S_LO_BAD) ? nqsf_pkg::CK_INVALID :
					{4'hF, 4'($urandom_range(0, 15))};
				sep = nqsf_pkg::CH_COMMA;
				pad = xor_of(body) ^ sep ^ target;
				if (pad == nqsf_pkg::CH_DOLLAR || pad == nqsf_pkg::CH_STAR ||
						pad == nqsf_pkg::CH_CR || pad == nqsf_pkg::CH_LF) begin
					sep = ";";
					pad = xor_of(body) ^ sep ^ target;
				end
				body.push_back(sep);
				body.push_back(pad);
			end
			default: ;
		endcase
		sum = xor_of(body);
		if (shape == S_BAD_SUM) sum ^= 8'($urandom_range(1, 255));
		if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 4)) line_q.push_back(filler_char());
		if (shape == S_RESTART_BODY) begin
			cut = $urandom_range(0, body.size() - 1);
			line_q.push_back(nqsf_pkg::CH_DOLLAR);
			for (int i = 0; i < cut; i++) line_q.push_back(body[i]);
		end else if (shape == S_RESTART_SUM) begin
			line_q.push_back(nqsf_pkg::CH_DOLLAR);
			line_q = {line_q, body};
			line_q.push_back(nqsf_pkg::CH_STAR);
			line_q.push_back(hex_char(sum[7:4], lower));
		end
		line_q.push_back(nqsf_pkg::CH_DOLLAR);
		line_q = {line_q, body};
		line_q.push_back(nqsf_pkg::CH_STAR);
		case (shape)
			S_HI_BAD: begin
				line_q.push_back(odd_char());
				line_q.push_back(hex_char(sum[3:0], lower));
			end
			S_LO_BAD: begin
				line_q.push_back($urandom_range(0, 1) ? hex_char(sum[7:4], lower) : odd_char());
				line_q.push_back(odd_char());
			end
			default: begin
				line_q.push_back(hex_char(sum[7:4], lower));
				line_q.push_back(hex_char(sum[3:0], lower));
			end
		endcase
		if ($urandom_range(0, 1)) begin
			line_q.push_back(nqsf_pkg::CH_CR);
			line_q.push_back(nqsf_pkg::CH_LF);
		end
	endtask

	// Entered and left at a falling edge; valid stays up across a burst.
	task automatic send_octet(input octet_t b);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200) :
				$urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		in_valid = 1'b1;
		rx_byte = b;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		bytes_sent++;
	endtask

	task automatic send_sentence();
		foreach (line_q[i]) send_octet(line_q[i]);
		sentences_sent++;
	endtask

	initial begin
		int     frames_before;
		int     bytes_start;
		int     id;
		shape_t shape;
		fill_t  fill;
		in_valid = 1'b0;
		rx_byte = '0;
		out_ready = 1'b0;
		arst_n = 1'b0;
		rx_mode = nqsf_pkg::MODE_WAIT;
		body_len = 0;
		body_xor = '0;
		sum_hi = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (plan[r]) begin
			frames_before = frames_made;
			build_sentence(plan[r].shape, plan[r].id, plan[r].fill);
			send_sentence();
			if (plan[r].want >= 0 && frames_made - frames_before != plan[r].want) begin
				note_fault($sformatf("directed row %0d (%s): %0d frames predicted, %0d expected",
					r, plan[r].shape.name(), frames_made - frames_before, plan[r].want));
			end
		end

		// Mostly well-formed sentences with random content, the rest broken or noise.
		bytes_start = bytes_sent;
		while (bytes_sent - bytes_start < RANDOM_BYTES) begin
			if ($urandom_range(0, 1)) shape = ($urandom_range(0, 3) == 0) ? S_TAIL : S_GOOD;
			else shape = shape_t'($urandom_range(0, S_NOISE));
			if (shape == S_ID_BIG) id = $urandom_range(nqsf_pkg::ID_MAX + 1, 99999);
			else if ($urandom_range(0, 3) == 0) id = $urandom_range(0, 1) ? nqsf_pkg::ID_MAX : 0;
			else id = $urandom_range(0, nqsf_pkg::ID_MAX);
			case ($urandom_range(0, 9))
				0: fill = FILL_ZERO;
				1: fill = FILL_ONES;
				default: fill = FILL_RANDOM;
			endcase
			build_sentence(shape, id, fill);
			send_sentence();
		end
		in_valid = 1'b0;

		while (pending_words.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d sentences (%0d bytes); %0d frames predicted, %0d words received.",
			sentences_sent, bytes_sent, frames_made, words_seen);
		$display({"Tag, id, run length, checksum, overflow, CR/LF and restart cases ",
			"ran under random stalls; %0d mismatches."}, faults);
		if (faults == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
